// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the point drawer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: rtl/bpd_pkg.sv
// ----------------------------------------------------------------------------
// Point drawer package
// Shared types and constants of the 1-bit BMP point drawer.
// ----------------------------------------------------------------------------
`default_nettype none

package bpd_pkg;

  localparam int DEF_MAX_WIDTH  = 128;
  localparam int DEF_MAX_HEIGHT = 64;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [7:0] MAGIC_B = 8'h42;
  localparam logic [7:0] MAGIC_M = 8'h4D;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_SKIP   = 2'd1,
    PH_PIXELS = 2'd2,
    PH_IDLE   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_POINT = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_BAD   = 2'd2,
    KIND_TRUNC = 2'd3
  } kind_t;

  // Work for one accepted byte: points to draw, then an optional status result.
  typedef struct packed {
    logic [7:0] mask;      // bit k set: draw column col_base + k
    logic [7:0] col_base;
    logic [7:0] row;
    logic       ev;
    kind_t      ev_kind;
  } job_t;

endpackage

`default_nettype wire

// File: rtl/bpd_queue.sv
// ----------------------------------------------------------------------------
// Job queue
// Short first-in first-out buffer between the parser and the point emitter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bpd_queue
  import bpd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  job_t      push_job,
  input  wire logic pop,
  output job_t      head,
  output logic      head_valid,
  output logic      full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign head       = entries[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (!push && pop) begin
        count <= count - CW'(1);
      end
    end
  end

  `ASSERT_CLK(a_no_overflow, push |-> (!full || pop), "push into a full queue")
  `ASSERT_CLK(a_no_underflow, pop |-> head_valid, "pop from an empty queue")
  `ASSERT_NEVER(a_count_range, count > CW'(DEPTH), "queue count out of range")

endmodule

`default_nettype wire

// File: rtl/bpd_front.sv
// ----------------------------------------------------------------------------
// Parser front end
// Walks the BMP header, skips to the pixel data and turns each byte into a job.
// ----------------------------------------------------------------------------
`default_nettype none

module bpd_front
  import bpd_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [7:0]  file_byte,
  input  wire logic        first_byte,
  input  wire logic        final_byte,
  input  wire logic [31:0] file_length,
  output logic             push,
  output job_t             push_job
);

  phase_t      phase, phase_next;
  logic [15:0] byte_offset;
  logic [15:0] declared_size;
  logic [15:0] data_offset;
  logic [31:0] info_header_size;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic [15:0] plane_count;
  logic [15:0] bit_depth;
  logic [7:0]  row_index;
  logic [7:0]  byte_in_row;
  logic        magic_ok;

  // State as seen by this byte; a restart mark clears it first.
  phase_t      cur_phase;
  logic [15:0] cur_off, cur_ds, cur_do, cur_w, cur_h, cur_pl, cur_bd;
  logic [31:0] cur_ih;
  logic [7:0]  cur_row, cur_bir;
  logic        cur_magic;

  logic [15:0] off_n, ds_n, do_n, w_n, h_n, pl_n, bd_n;
  logic [31:0] ih_n;
  logic [7:0]  row_n, bir_n;
  logic        magic_n;

  logic [31:0] do_rel;
  logic [5:0]  hdr_len;
  logic [5:0]  hdr_last;
  logic        short_file;
  logic        hdr_last_byte;
  logic [31:0] ih_plus14;
  logic [15:0] fsize;
  logic        size_ok;
  logic        hdr_good;
  logic        empty_image;
  logic [15:0] off_inc;
  logic [8:0]  data_bytes;
  logic [8:0]  row_bytes;
  logic [8:0]  bir_inc;
  logic        row_wrap;
  logic [7:0]  pix_mask;
  logic        done_ev;
  logic        bad_ev;
  phase_t      phase_mid;

  assign cur_phase = first_byte ? PH_HEADER : phase;
  assign cur_off   = first_byte ? '0 : byte_offset;
  assign cur_ds    = first_byte ? '0 : declared_size;
  assign cur_do    = first_byte ? '0 : data_offset;
  assign cur_ih    = first_byte ? '0 : info_header_size;
  assign cur_w     = first_byte ? '0 : image_width;
  assign cur_h     = first_byte ? '0 : image_height;
  assign cur_pl    = first_byte ? '0 : plane_count;
  assign cur_bd    = first_byte ? '0 : bit_depth;
  assign cur_row   = first_byte ? '0 : row_index;
  assign cur_bir   = first_byte ? '0 : byte_in_row;
  assign cur_magic = first_byte ? 1'b0 : magic_ok;

  // Header length is data offset minus 14, wrapped, clamped to 4..32.
  assign do_rel   = {16'b0, cur_do} - 32'd14;
  assign hdr_len  = (do_rel < 32'd4) ? 6'd4 : ((do_rel > 32'd32) ? 6'd32 : do_rel[5:0]);
  assign hdr_last = 6'd13 + hdr_len;

  assign short_file    = (cur_off == '0) && (file_length < 32'd14);
  assign hdr_last_byte = (cur_off == {10'b0, hdr_last});
  assign off_inc       = cur_off + 16'd1;

  // Header capture.
  always_comb begin
    ds_n    = cur_ds;
    do_n    = cur_do;
    ih_n    = cur_ih;
    w_n     = cur_w;
    h_n     = cur_h;
    pl_n    = cur_pl;
    bd_n    = cur_bd;
    magic_n = cur_magic;
    if (cur_phase == PH_HEADER && !short_file) begin
      unique case (cur_off[5:0])
        6'd0:  magic_n = (file_byte == MAGIC_B);
        6'd1:  magic_n = cur_magic && (file_byte == MAGIC_M);
        6'd2:  ds_n[7:0]  = file_byte;
        6'd3:  ds_n[15:8] = file_byte;
        6'd10: do_n[7:0]  = file_byte;
        6'd11: do_n[15:8] = file_byte;
        6'd14: ih_n[7:0]   = cur_ih[7:0] | file_byte;
        6'd15: ih_n[15:8]  = cur_ih[15:8] | file_byte;
        6'd16: ih_n[23:16] = cur_ih[23:16] | file_byte;
        6'd17: ih_n[31:24] = cur_ih[31:24] | file_byte;
        6'd18: w_n[7:0]  = file_byte;
        6'd19: w_n[15:8] = file_byte;
        6'd20: if (cur_ih == 32'd12) h_n[7:0] = file_byte;
        6'd21: if (cur_ih == 32'd12) h_n[15:8] = file_byte;
        6'd22: begin
          if (cur_ih == 32'd12) pl_n[7:0] = file_byte;
          else h_n[7:0] = file_byte;
        end
        6'd23: begin
          if (cur_ih == 32'd12) pl_n[15:8] = file_byte;
          else h_n[15:8] = file_byte;
        end
        6'd24: if (cur_ih == 32'd12) bd_n[7:0] = file_byte;
        6'd25: if (cur_ih == 32'd12) bd_n[15:8] = file_byte;
        6'd26: if (cur_ih != 32'd12) pl_n[7:0] = file_byte;
        6'd27: if (cur_ih != 32'd12) pl_n[15:8] = file_byte;
        6'd28: if (cur_ih != 32'd12) bd_n[7:0] = file_byte;
        6'd29: if (cur_ih != 32'd12) bd_n[15:8] = file_byte;
        default: ;
      endcase
    end
  end

  // Header check on the captured values, with the declared size repaired first.
  assign ih_plus14 = ih_n + 32'd14;
  assign fsize     = ((ds_n == 16'd14) || ({16'b0, ds_n} == ih_plus14)) ?
                     16'(file_length - 32'd2) : ds_n;
  assign size_ok   = (ih_n == 32'd12) || (ih_n == 32'd40) || (ih_n == 32'd56) ||
                     (ih_n == 32'd64) || (ih_n == 32'd108) || (ih_n == 32'd124);
  assign hdr_good  = magic_n && (ih_plus14 <= {16'b0, do_n}) && (fsize > do_n) &&
                     size_ok && (pl_n == 16'd1) && (bd_n == 16'd1) &&
                     (w_n <= 16'(MAX_WIDTH)) && (h_n <= 16'(MAX_HEIGHT));
  assign empty_image = (w_n == '0) || (h_n == '0);

  // Pixel row geometry; the width is at most eight bits once validated.
  assign data_bytes = ({1'b0, cur_w[7:0]} + 9'd7) >> 3;
  assign row_bytes  = (({1'b0, cur_w[7:0]} + 9'd31) >> 5) << 2;
  assign bir_inc    = {1'b0, cur_bir} + 9'd1;
  assign row_wrap   = (bir_inc >= row_bytes);

  always_comb begin
    logic [10:0] col;
    pix_mask = '0;
    for (int k = 0; k < 8; k++) begin
      col = {cur_bir, 3'b000} + 11'(k);
      pix_mask[k] = ({1'b0, cur_bir} < data_bytes) && (col < {3'b0, cur_w[7:0]}) &&
                    !file_byte[7-k];
    end
  end

  // Phase sequencing before the final-byte check.
  always_comb begin
    phase_mid = cur_phase;
    unique case (cur_phase)
      PH_HEADER: begin
        if (short_file) begin
          phase_mid = PH_IDLE;
        end else if (hdr_last_byte) begin
          if (!hdr_good || empty_image) phase_mid = PH_IDLE;
          else if (off_inc == do_n) phase_mid = PH_PIXELS;
          else phase_mid = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (off_inc >= cur_do) phase_mid = PH_PIXELS;
      end
      PH_PIXELS: begin
        if (row_wrap && cur_row == '0) phase_mid = PH_IDLE;
      end
      PH_IDLE: ;
      default: ;
    endcase
    phase_next = (final_byte && phase_mid != PH_IDLE) ? PH_IDLE : phase_mid;
  end

  // Job contents and datapath updates.
  always_comb begin
    off_n   = cur_off;
    row_n   = cur_row;
    bir_n   = cur_bir;
    done_ev = 1'b0;
    bad_ev  = 1'b0;
    unique case (cur_phase)
      PH_HEADER: begin
        if (short_file) begin
          bad_ev = 1'b1;
        end else begin
          off_n = off_inc;
          if (hdr_last_byte) begin
            if (!hdr_good) begin
              bad_ev = 1'b1;
            end else if (empty_image) begin
              done_ev = 1'b1;
            end else begin
              row_n = h_n[7:0] - 8'd1;
              bir_n = '0;
            end
          end
        end
      end
      PH_SKIP: off_n = off_inc;
      PH_PIXELS: begin
        if (row_wrap) begin
          bir_n = '0;
          if (cur_row == '0) done_ev = 1'b1;
          else row_n = cur_row - 8'd1;
        end else begin
          bir_n = bir_inc[7:0];
        end
      end
      PH_IDLE: ;
      default: ;
    endcase
  end

  always_comb begin
    push_job          = '0;
    push_job.mask     = (cur_phase == PH_PIXELS) ? pix_mask : 8'b0;
    push_job.col_base = {cur_bir[4:0], 3'b000};
    push_job.row      = cur_row;
    push_job.ev_kind  = KIND_DONE;
    if (bad_ev) begin
      push_job.ev      = 1'b1;
      push_job.ev_kind = KIND_BAD;
    end else if (done_ev) begin
      push_job.ev      = 1'b1;
      push_job.ev_kind = KIND_DONE;
    end else if (final_byte && phase_mid != PH_IDLE) begin
      push_job.ev      = 1'b1;
      push_job.ev_kind = (phase_mid == PH_HEADER) ? KIND_BAD : KIND_TRUNC;
    end
  end

  assign push = accept && ((push_job.mask != '0) || push_job.ev);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      byte_offset      <= '0;
      declared_size    <= '0;
      data_offset      <= '0;
      info_header_size <= '0;
      image_width      <= '0;
      image_height     <= '0;
      plane_count      <= '0;
      bit_depth        <= '0;
      row_index        <= '0;
      byte_in_row      <= '0;
      magic_ok         <= 1'b0;
    end else if (accept) begin
      phase            <= phase_next;
      byte_offset      <= off_n;
      declared_size    <= ds_n;
      data_offset      <= do_n;
      info_header_size <= ih_n;
      image_width      <= w_n;
      image_height     <= h_n;
      plane_count      <= pl_n;
      bit_depth        <= bd_n;
      row_index        <= row_n;
      byte_in_row      <= bir_n;
      magic_ok         <= magic_n;
    end
  end

endmodule

`default_nettype wire

// File: rtl/bpd_back.sv
// ----------------------------------------------------------------------------
// Point emitter back end
// Expands queued jobs into the output register, one result per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bpd_back
  import bpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  origin_x,
  input  wire logic [7:0]  origin_y,
  input  job_t             head,
  input  wire logic        head_valid,
  output logic             pop,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // kind[1:0], point_x[9:2], point_y[17:10], zeros
  output logic             m_axis_tlast    // run_end
);

  job_t       job;
  logic       job_active;
  job_t       cur;
  logic       cur_valid;
  logic       slot_free;
  logic       fire;
  logic [2:0] pick;
  logic       has_pt;
  logic [7:0] rem_mask;
  job_t       rem;
  logic       rem_empty;
  kind_t      out_kind;
  logic [7:0] out_x;
  logic [7:0] out_y;

  assign cur       = job_active ? job : head;
  assign cur_valid = job_active || head_valid;
  assign slot_free = !m_axis_tvalid || m_axis_tready;
  assign fire      = slot_free && cur_valid;
  assign pop       = fire && !job_active;
  assign has_pt    = (cur.mask != '0);

  // Lowest set bit first: columns go out left to right.
  always_comb begin
    pick = '0;
    for (int k = 7; k >= 0; k--) begin
      if (cur.mask[k]) pick = 3'(k);
    end
  end

  assign rem_mask = cur.mask & ~(8'b1 << pick);

  always_comb begin
    rem      = cur;
    rem.mask = rem_mask;
    if (!has_pt) rem.ev = 1'b0;
  end

  assign rem_empty = (rem.mask == '0) && !rem.ev;
  assign out_kind  = has_pt ? KIND_POINT : cur.ev_kind;
  assign out_x     = has_pt ? origin_x + cur.col_base + {5'b0, pick} : 8'b0;
  assign out_y     = has_pt ? origin_y + cur.row : 8'b0;

  always_ff @(posedge clk) begin
    if (fire) begin
      m_axis_tdata <= {6'b0, out_y, out_x, out_kind};
      m_axis_tlast <= rem_empty;
      job          <= rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      job_active    <= 1'b0;
    end else begin
      if (fire) begin
        m_axis_tvalid <= 1'b1;
        job_active    <= !rem_empty;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  `ASSERT_CLK(a_job_nonempty, job_active |-> ((job.mask != '0) || job.ev),
              "active job has nothing left to emit")
  `ASSERT_CLK(a_status_ends_run, (fire && !has_pt) |-> rem_empty,
              "status result is not the last of its byte")

endmodule

`default_nettype wire

// File: rtl/bmp_1bit_point_drawer_unit.sv
// ----------------------------------------------------------------------------
// 1-bit BMP point drawer
// Parses a monochrome BMP byte stream and emits a draw point per black pixel.
// ----------------------------------------------------------------------------
// The parser takes one file byte per cycle whenever its four-entry job queue
// has room, and the emitter drains that queue at one result per cycle while
// the output is not stalled: a pixel byte yields one point per zero bit
// within the image width plus a trailing status result where one is due, so
// at most nine results, and header, skip and all-white bytes yield no points.
// Sustained input rate is therefore set by the emitter and by the results of
// each byte. Status results (done, bad header, truncated) always close the
// run of the byte that caused them and are marked by tlast.
`default_nettype none

module bmp_1bit_point_drawer_unit
  import bpd_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // file_byte
  input  wire logic        s_axis_tuser,   // first_byte
  input  wire logic        s_axis_tlast,   // final_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // kind[1:0], point_x[9:2], point_y[17:10], zeros
  output logic             m_axis_tlast,   // run_end
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam logic [1:0] REG_ORIGIN_X    = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y    = 2'd1;
  localparam logic [1:0] REG_FILE_LENGTH = 2'd2;

  logic [7:0]  origin_x;
  logic [7:0]  origin_y;
  logic [31:0] file_length;
  logic        accept;
  logic        push;
  job_t        push_job;
  job_t        head;
  logic        head_valid;
  logic        pop;
  logic        full;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x    <= '0;
      origin_y    <= '0;
      file_length <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN_X:    origin_x    <= cfg_data[7:0];
        REG_ORIGIN_Y:    origin_y    <= cfg_data[7:0];
        REG_FILE_LENGTH: file_length <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  bpd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .file_byte   (s_axis_tdata),
    .first_byte  (s_axis_tuser),
    .final_byte  (s_axis_tlast),
    .file_length (file_length),
    .push        (push),
    .push_job    (push_job)
  );

  bpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (full)
  );

  bpd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .origin_x      (origin_x),
    .origin_y      (origin_y),
    .head          (head),
    .head_valid    (head_valid),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// File: verif/bpd_tb_pkg.sv
// ----------------------------------------------------------------------------
// Point drawer testbench package
// Register indexes of the configuration port shared by checker and stimulus.
// ----------------------------------------------------------------------------
package bpd_tb_pkg;

  localparam logic [1:0] REG_ORIGIN_X    = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y    = 2'd1;
  localparam logic [1:0] REG_FILE_LENGTH = 2'd2;

endpackage

// File: verif/bpd_checker.sv
// ----------------------------------------------------------------------------
// Point drawer checker
// Watches the byte, result and register channels, predicts the results of
// every accepted file byte and compares each result transfer in order.
// ----------------------------------------------------------------------------
module bpd_checker
  import bpd_pkg::*;
  import bpd_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fails,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    kind_t      kind;
    logic [7:0] x;
    logic [7:0] y;
    logic       last;
  } draw_t;

  draw_t draws_due[$];

  logic [7:0]  org_x, org_y;
  logic [31:0] flen;
  logic [31:0] pos;
  phase_t      ph;
  logic [15:0] dsize, doff;
  logic [31:0] ihs;
  logic [15:0] wid, hgt, planes, depth;
  logic [7:0]  row, bir;
  bit          magic;

  task automatic clear_parser();
    pos = 0; ph = PH_HEADER; dsize = 0; doff = 0; ihs = 0;
    wid = 0; hgt = 0; planes = 0; depth = 0; row = 0; bir = 0; magic = 0;
  endtask

  function automatic logic [31:0] header_stop();
    logic [31:0] len;
    len = {16'h0, doff} - 32'd14;
    if (len < 4) len = 4;
    if (len > 32) len = 32;
    return 32'd14 + len;
  endfunction

  task automatic capture(input logic [31:0] o, input logic [7:0] b);
    bit os2;
    os2 = (ihs == 32'd12);
    if (o == 0) magic = (b == MAGIC_B);
    else if (o == 1) magic = magic && (b == MAGIC_M);
    else if (o == 2) dsize[7:0] = b;
    else if (o == 3) dsize[15:8] = b;
    else if (o == 10) doff[7:0] = b;
    else if (o == 11) doff[15:8] = b;
    else if (o >= 14 && o <= 17) ihs |= 32'(b) << (8 * (o - 14));
    else if (o == 18) wid[7:0] = b;
    else if (o == 19) wid[15:8] = b;
    else if (os2) begin
      if (o == 20) hgt[7:0] = b;
      else if (o == 21) hgt[15:8] = b;
      else if (o == 22) planes[7:0] = b;
      else if (o == 23) planes[15:8] = b;
      else if (o == 24) depth[7:0] = b;
      else if (o == 25) depth[15:8] = b;
    end else begin
      if (o == 22) hgt[7:0] = b;
      else if (o == 23) hgt[15:8] = b;
      else if (o == 26) planes[7:0] = b;
      else if (o == 27) planes[15:8] = b;
      else if (o == 28) depth[7:0] = b;
      else if (o == 29) depth[15:8] = b;
    end
  endtask

  function automatic bit header_ok();
    logic [15:0] fsize;
    logic [31:0] ih14;
    ih14 = ihs + 32'd14;
    fsize = dsize;
    if (!magic) return 0;
    if (ih14 > {16'h0, doff}) return 0;
    // A size field of 14 or of the header length is taken as unset.
    if (fsize == 16'd14 || {16'h0, fsize} == ih14) fsize = 16'(flen - 32'd2);
    if (fsize <= doff) return 0;
    if (!(ihs == 12 || ihs == 40 || ihs == 56 || ihs == 64 || ihs == 108 || ihs == 124))
      return 0;
    if (planes != 1 || depth != 1) return 0;
    if (wid > DEF_MAX_WIDTH || hgt > DEF_MAX_HEIGHT) return 0;
    return 1;
  endfunction

  task automatic predict_byte(input logic [7:0] b, input bit first, input bit fin);
    draw_t run[$];
    draw_t d;
    logic [31:0] o;
    int unsigned w, data_bytes, row_bytes, col;
    d.last = 0; d.x = 0; d.y = 0;
    if (first) clear_parser();
    case (ph)
      PH_HEADER: begin
        o = pos;
        if (o == 0 && flen < 14) begin
          d.kind = KIND_BAD; run.push_back(d); ph = PH_IDLE;
        end else begin
          capture(o, b);
          pos = o + 1;
          if (o >= 11 && o + 1 == header_stop()) begin
            if (!header_ok()) begin
              d.kind = KIND_BAD; run.push_back(d); ph = PH_IDLE;
            end else if (wid == 0 || hgt == 0) begin
              d.kind = KIND_DONE; run.push_back(d); ph = PH_IDLE;
            end else begin
              row = 8'(hgt - 16'd1);
              bir = 0;
              ph = (pos == {16'h0, doff}) ? PH_PIXELS : PH_SKIP;
            end
          end
        end
      end
      PH_SKIP: begin
        pos = pos + 1;
        if (pos >= {16'h0, doff}) ph = PH_PIXELS;
      end
      PH_PIXELS: begin
        w = wid;
        data_bytes = (w + 7) / 8;
        row_bytes = ((w + 31) / 32) * 4;
        if (bir < data_bytes) begin
          for (int k = 0; k < 8; k++) begin
            col = bir * 8 + k;
            if (col < w && !b[7-k]) begin
              d.kind = KIND_POINT;
              d.x = 8'(org_x + col);
              d.y = org_y + row;
              run.push_back(d);
            end
          end
        end
        d.x = 0; d.y = 0;
        bir = bir + 1;
        if (bir >= row_bytes) begin
          bir = 0;
          if (row == 0) begin
            d.kind = KIND_DONE; run.push_back(d); ph = PH_IDLE;
          end else begin
            row = row - 1;
          end
        end
      end
      default: ;
    endcase
    if (fin && ph != PH_IDLE) begin
      d.kind = (ph == PH_HEADER) ? KIND_BAD : KIND_TRUNC;
      run.push_back(d);
      ph = PH_IDLE;
    end
    if (run.size() > 0) run[run.size()-1].last = 1;
    foreach (run[i]) draws_due.push_back(run[i]);
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("[%0t] mismatch: %s got %0d, expected %0d", $realtime, what, got, want);
    fails++;
  endtask

  task automatic check_result();
    draw_t e;
    if (draws_due.size() == 0) begin
      $display("[%0t] mismatch: result transfer with none expected, data %h",
               $realtime, m_axis_tdata);
      fails++;
    end else begin
      e = draws_due.pop_front();
      if (m_axis_tdata[1:0] != e.kind) report_mismatch("kind", m_axis_tdata[1:0], e.kind);
      if (m_axis_tdata[9:2] != e.x) report_mismatch("point_x", m_axis_tdata[9:2], e.x);
      if (m_axis_tdata[17:10] != e.y) report_mismatch("point_y", m_axis_tdata[17:10], e.y);
      if (m_axis_tdata[23:18] != 0) report_mismatch("pad bits", m_axis_tdata[23:18], 0);
      if (m_axis_tlast != e.last) report_mismatch("run_end", m_axis_tlast, e.last);
    end
  endtask

  initial fails = 0;

  always @(posedge clk) begin
    if (rst) begin
      org_x = 0; org_y = 0; flen = 0;
      clear_parser();
      draws_due.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (cfg_we) begin
        case (cfg_index)
          REG_ORIGIN_X:    org_x = cfg_data[7:0];
          REG_ORIGIN_Y:    org_y = cfg_data[7:0];
          REG_FILE_LENGTH: flen = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast);
    end
    pending <= draws_due.size();
  end

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// Point drawer testbench
// Streams small monochrome BMP files, well formed and damaged, through the
// point drawer under random input gaps and output stalls; the checker
// predicts every result and the top gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import bpd_pkg::*;
  import bpd_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;

  logic        clk, rst;
  logic        s_axis_tvalid, s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser, s_axis_tlast;
  logic        m_axis_tvalid, m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  int          fails, pending;

  logic [7:0]  file_q[$];
  int          burst_left;
  int          bytes_sent;
  bit          long_hold;
  int          quiet_cycles;

  bmp_1bit_point_drawer_unit DUT (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_we, .cfg_index, .cfg_data
  );

  bpd_checker u_chk (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_we, .cfg_index, .cfg_data,
    .fails, .pending
  );

  initial clk = 0;
  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // Receiver: changes its stall pattern now and then; a long hold-off
  // lets the job queue fill so the input side backs up.
  initial begin : receiver
    int mode, left, hold;
    m_axis_tready = 0;
    mode = 0; left = 0; hold = 0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        long_hold = 0;
        hold = 400;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 96);
      end
      left--;
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 0;
      end else begin
        case (mode)
          0: m_axis_tready <= 1;
          1: m_axis_tready <= $urandom_range(0, 1);
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= (left % 5 != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit first, input bit fin);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        s_axis_tvalid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= first;
    s_axis_tlast  <= fin;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // Stop offering, wait for every expected result, then let the block settle.
  task automatic drain();
    s_axis_tvalid <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic program_regs(input logic [7:0] ox, input logic [7:0] oy,
                              input logic [31:0] flen);
    cfg_we <= 1; cfg_index <= REG_ORIGIN_X; cfg_data <= {24'h0, ox};
    @(posedge clk);
    cfg_index <= REG_ORIGIN_Y; cfg_data <= {24'h0, oy};
    @(posedge clk);
    cfg_index <= REG_FILE_LENGTH; cfg_data <= flen;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic push_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) file_q.push_back(v[8*i +: 8]);
  endtask

  // size_mode: 0 true length, 1 fourteen, 2 header length, 3 random.
  task automatic build_bmp(input int ih, input int w, input int h, input int extra,
                           input int size_mode);
    int doff, rb, r;
    logic [31:0] sz;
    file_q.delete();
    doff = 14 + ih + extra;
    rb = ((w + 31) / 32) * 4;
    file_q.push_back(MAGIC_B);
    file_q.push_back(MAGIC_M);
    push_le(0, 4);
    push_le(0, 4);
    push_le(doff, 4);
    push_le(ih, 4);
    if (ih == 12) begin
      push_le(w, 2); push_le(h, 2); push_le(1, 2); push_le(1, 2);
    end else begin
      push_le(w, 4); push_le(h, 4); push_le(1, 2); push_le(1, 2);
    end
    while (file_q.size() < 14 + ih) file_q.push_back(8'h00);
    repeat (extra) file_q.push_back($urandom_range(0, 255));
    repeat (rb * h) begin
      r = $urandom_range(0, 3);
      file_q.push_back(r == 0 ? 8'hFF : r == 1 ? 8'h00 : 8'($urandom_range(0, 255)));
    end
    case (size_mode)
      0: sz = file_q.size();
      1: sz = 14;
      2: sz = ih + 14;
      default: sz = $urandom;
    endcase
    for (int i = 0; i < 4; i++) file_q[2+i] = sz[8*i +: 8];
  endtask

  task automatic send_file(input bit mark, input int cut, input bit mark_end);
    int n;
    n = (cut > 0 && cut < file_q.size()) ? cut : file_q.size();
    for (int i = 0; i < n; i++)
      send_byte(file_q[i], (i == 0) && mark, (i == n - 1) && (mark_end || cut > 0));
  endtask

  task automatic random_file(input bit hold_off);
    int ih, w, h, extra, r, cut;
    logic [31:0] flen;
    logic [7:0] ox, oy;
    r = $urandom_range(0, 19);
    ih = r < 12 ? 12 : r < 15 ? 40 : r == 15 ? 56 : r == 16 ? 64 :
         r == 17 ? 108 : r == 18 ? 124 : 20;
    r = $urandom_range(0, 19);
    w = r == 0 ? 0 : r == 1 ? 128 : r == 2 ? 129 : $urandom_range(1, 40);
    r = $urandom_range(0, 29);
    h = r == 0 ? 0 : r == 1 ? 65 : r == 2 ? 64 : $urandom_range(1, 3);
    if (h >= 64) w = $urandom_range(1, 8);
    extra = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 0;
    build_bmp(ih, w, h, extra, $urandom_range(0, 3));
    if ($urandom_range(0, 5) == 0)
      file_q[$urandom_range(0, (file_q.size() < 30) ? file_q.size() - 1 : 29)] =
        $urandom_range(0, 255);
    r = $urandom_range(0, 11);
    flen = r == 0 ? $urandom : r == 1 ? $urandom_range(0, 13) : file_q.size();
    r = $urandom_range(0, 5);
    ox = r == 0 ? 8'h00 : r == 1 ? 8'hFF : 8'($urandom_range(0, 255));
    r = $urandom_range(0, 5);
    oy = r == 0 ? 8'h00 : r == 1 ? 8'hFF : 8'($urandom_range(0, 255));
    cut = ($urandom_range(0, 6) == 0) ? $urandom_range(1, file_q.size()) : 0;
    drain();
    program_regs(ox, oy, flen);
    if (hold_off) long_hold = 1;
    send_file($urandom_range(0, 14) != 0, cut, $urandom_range(0, 1));
    // Trailing bytes after the end of a file are normally ignored.
    repeat ($urandom_range(0, 2))
      send_byte($urandom_range(0, 255), 0, $urandom_range(0, 1));
  endtask

  initial begin : stimulus
    int nfile;
    rst = 1;
    s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tuser = 0; s_axis_tlast = 0;
    cfg_we = 0; cfg_index = 0; cfg_data = 0;
    burst_left = 0; bytes_sent = 0; long_hold = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // After reset the first byte counts as byte zero without a restart mark.
    build_bmp(12, 8, 1, 0, 0);
    program_regs(8'hFF, 8'hFF, file_q.size());
    file_q[26] = 8'h5A;
    send_file(0, 0, 1);
    drain();
    // A file length below the file header is refused on byte zero.
    program_regs(8'h00, 8'h00, 32'd13);
    send_byte(MAGIC_B, 1, 0);
    drain();
    // End of stream inside the header.
    program_regs(8'h80, 8'h01, 32'hFFFF_FFFF);
    build_bmp(40, 16, 1, 8, 0);
    send_file(1, 6, 1);

    nfile = 0;
    bytes_sent = 0;
    while (bytes_sent < 280) begin
      random_file(nfile == 2);
      nfile++;
    end

    drain();
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/bpd_pkg.sv
rtl/bpd_queue.sv
rtl/bpd_front.sv
rtl/bpd_back.sv
rtl/bmp_1bit_point_drawer_unit.sv
verif/bpd_tb_pkg.sv
verif/bpd_checker.sv
verif/tb.sv
